// ===== hdl/ctft_pkg.sv =====
package ctft_pkg;

  // Field widths of the request and result items.
  localparam int TIME_W  = 63;
  localparam int ADDR_W  = 56;
  localparam int CHUNK_W = 47;
  localparam int COUNT_W = 17;
  localparam int TIER_W  = 2;

  // Configuration register widths.
  localparam int MIB_W      = 11;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  // One MiB is 2048 sectors and one sector is 512 bytes.
  localparam int MIB_SHIFT    = 11;
  localparam int SECTOR_SHIFT = 9;

  // The serial divider works on the sector address with the MiB shift taken off.
  localparam int DIVIDEND_W = ADDR_W - MIB_SHIFT;

  // Default bitmap depth.
  localparam int CHUNK_SLOTS_DEF = 65536;

  // Packed stream widths, filled up to whole bytes.
  localparam int IN_FIELDS_W  = TIME_W + ADDR_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * CHUNK_W + TIME_W + 2 + TIER_W + 4 * COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_SIZE_MIB     = 2'd0,
    REG_FAST_TIER_CHUNKS   = 2'd1,
    REG_MIDDLE_TIER_CHUNKS = 2'd2,
    REG_ADDRESS_IN_BYTES   = 2'd3
  } reg_idx_t;

  // Placement tiers.
  typedef enum logic [TIER_W-1:0] {
    TIER_SCM = 2'd0,
    TIER_SSD = 2'd1,
    TIER_HDD = 2'd2
  } tier_t;

  // Counter increment that sticks at the all-ones value.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

// ===== hdl/chunk_first_touch_tier_tracker.sv =====
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  in_tdata: request_time, request_address
// out_     master     out_tvalid/out_tready out_tdata: one result item per request
// cfg_     write only cfg_wr_en            cfg_index, cfg_wr_data
//
// Each item passes through the accept step, the restoring divider (one quotient
// bit per cycle through a single 13-bit subtractor), a bitmap read step and a
// decide step. After reset the bitmap is cleared one entry per cycle, and no
// item is accepted during that pass.
// A result waits in the output register while the next item is taken; the
// decide step holds until that register is free.
module chunk_first_touch_tier_tracker #(
  parameter int CHUNK_SLOTS = ctft_pkg::CHUNK_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input item: request_time [62:0], request_address [118:63], zero fill above.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ctft_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result item: chunk_number [46:0], in_range [47], first_touch [48],
  // tier [50:49], unique_chunks [67:51], lowest_chunk [114:68],
  // highest_chunk [161:115], start_time [224:162], placed_fast [241:225],
  // placed_middle [258:242], placed_slow [275:259], zero fill above.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ctft_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration write port.
  input  logic                               cfg_wr_en,
  input  logic [ctft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctft_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
  import ctft_pkg::*;

  localparam int SLOT_W = $clog2(CHUNK_SLOTS);
  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_DECIDE
  } state_t;

  // Control and working registers.
  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;
  logic [MIB_W-1:0]    rem_r, rem_nxt;
  logic                in_range_r, in_range_nxt;
  tier_t               tier_r, tier_nxt;

  // Configuration registers.
  logic [MIB_W-1:0]    chunk_size_mib_r, chunk_size_mib_nxt;
  logic [COUNT_W-1:0]  fast_tier_r, fast_tier_nxt;
  logic [COUNT_W-1:0]  middle_tier_r, middle_tier_nxt;
  logic                addr_bytes_r, addr_bytes_nxt;

  // Tracking state.
  logic                seen_any_r, seen_any_nxt;
  logic [TIME_W-1:0]   first_stamp_r, first_stamp_nxt;
  logic [CHUNK_W-1:0]  min_index_r, min_index_nxt;
  logic [CHUNK_W-1:0]  max_index_r, max_index_nxt;
  logic [COUNT_W-1:0]  distinct_r, distinct_nxt;
  logic [COUNT_W-1:0]  fast_cnt_r, fast_cnt_nxt;
  logic [COUNT_W-1:0]  middle_cnt_r, middle_cnt_nxt;
  logic [COUNT_W-1:0]  slow_cnt_r, slow_cnt_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Bitmap memory ports.
  logic                mem [CHUNK_SLOTS];
  logic                mem_q_r;
  logic                mem_rd_en;
  logic                mem_wr_en;
  logic [SLOT_W-1:0]   mem_wr_addr;
  logic                mem_wr_data;

  // Shared divider step and item fields.
  logic [MIB_W-1:0]    divisor;
  logic [MIB_W:0]      partial;
  logic [MIB_W+1:0]    diff;
  logic                ge;
  logic [CHUNK_W-1:0]  chunk;
  logic [COUNT_W:0]    tier_sum;
  logic [TIME_W-1:0]   in_time;
  logic [ADDR_W-1:0]   in_addr;
  logic                first;

  assign in_time = in_tdata[TIME_W-1:0];
  assign in_addr = in_tdata[TIME_W+ADDR_W-1:TIME_W];

  // A zero chunk size counts as one MiB.
  assign divisor = (chunk_size_mib_r == '0) ? MIB_W'(1) : chunk_size_mib_r;

  // One restoring division step: compare the shifted remainder with the divisor.
  assign partial = {rem_r, dq_r[DIVIDEND_W-1]};
  assign diff    = {1'b0, partial} - {2'b00, divisor};
  assign ge      = ~diff[MIB_W+1];

  assign chunk    = CHUNK_W'(dq_r);
  assign tier_sum = {1'b0, fast_tier_r} + {1'b0, middle_tier_r};
  assign first    = in_range_r & ~mem_q_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt          = state_r;
    clr_addr_nxt       = clr_addr_r;
    step_nxt           = step_r;
    dq_nxt             = dq_r;
    rem_nxt            = rem_r;
    in_range_nxt       = in_range_r;
    tier_nxt           = tier_r;
    chunk_size_mib_nxt = chunk_size_mib_r;
    fast_tier_nxt      = fast_tier_r;
    middle_tier_nxt    = middle_tier_r;
    addr_bytes_nxt     = addr_bytes_r;
    seen_any_nxt       = seen_any_r;
    first_stamp_nxt    = first_stamp_r;
    min_index_nxt      = min_index_r;
    max_index_nxt      = max_index_r;
    distinct_nxt       = distinct_r;
    fast_cnt_nxt       = fast_cnt_r;
    middle_cnt_nxt     = middle_cnt_r;
    slow_cnt_nxt       = slow_cnt_r;
    out_valid_nxt      = out_valid_r & ~out_tready;
    out_data_nxt       = out_data_r;
    mem_rd_en          = 1'b0;
    mem_wr_en          = 1'b0;
    mem_wr_addr        = clr_addr_r;
    mem_wr_data        = 1'b0;

    // Register writes are to arrive only while the block is idle; the block itself does not enforce it.
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_CHUNK_SIZE_MIB:     chunk_size_mib_nxt = cfg_wr_data[MIB_W-1:0];
        REG_FAST_TIER_CHUNKS:   fast_tier_nxt      = cfg_wr_data;
        REG_MIDDLE_TIER_CHUNKS: middle_tier_nxt    = cfg_wr_data;
        REG_ADDRESS_IN_BYTES:   addr_bytes_nxt     = cfg_wr_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      // Clearing pass over the bitmap after reset.
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
        if (clr_addr_r == SLOT_W'(CHUNK_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + SLOT_W'(1);
        end
      end

      // Take an item and load the dividend in MiB units.
      ST_IDLE: begin
        if (in_tvalid) begin
          if (!seen_any_r) begin
            seen_any_nxt    = 1'b1;
            first_stamp_nxt = in_time;
          end
          if (addr_bytes_nxt) begin
            dq_nxt = DIVIDEND_W'(in_addr[ADDR_W-1:MIB_SHIFT+SECTOR_SHIFT]);
          end else begin
            dq_nxt = in_addr[ADDR_W-1:MIB_SHIFT];
          end
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end

      // One quotient bit per cycle shifts in as the dividend shifts out.
      ST_DIV: begin
        rem_nxt = ge ? diff[MIB_W-1:0] : partial[MIB_W-1:0];
        dq_nxt  = {dq_r[DIVIDEND_W-2:0], ge};
        if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
          state_nxt = ST_LOOK;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end

      // Range, tier and extremes; start the bitmap read.
      ST_LOOK: begin
        mem_rd_en    = 1'b1;
        in_range_nxt = (chunk < CHUNK_W'(CHUNK_SLOTS));
        if (chunk < CHUNK_W'(fast_tier_r)) begin
          tier_nxt = TIER_SCM;
        end else if (chunk < CHUNK_W'(tier_sum)) begin
          tier_nxt = TIER_SSD;
        end else begin
          tier_nxt = TIER_HDD;
        end
        if (chunk < min_index_r) min_index_nxt = chunk;
        if (chunk > max_index_r) max_index_nxt = chunk;
        state_nxt = ST_DECIDE;
      end

      // Record a first touch and load the result once the output is free.
      ST_DECIDE: begin
        if (!out_valid_r || out_tready) begin
          mem_wr_addr = dq_r[SLOT_W-1:0];
          mem_wr_data = 1'b1;
          if (first) begin
            mem_wr_en    = 1'b1;
            distinct_nxt = sat_inc(distinct_r);
            unique case (tier_r)
              TIER_SCM: fast_cnt_nxt   = sat_inc(fast_cnt_r);
              TIER_SSD: middle_cnt_nxt = sat_inc(middle_cnt_r);
              default:  slow_cnt_nxt   = sat_inc(slow_cnt_r);
            endcase
          end
          out_data_nxt = OUT_TDATA_W'({slow_cnt_nxt, middle_cnt_nxt, fast_cnt_nxt,
                                       first_stamp_r, max_index_r, min_index_r,
                                       distinct_nxt, tier_r, first, in_range_r, chunk});
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      clr_addr_r       <= '0;
      step_r           <= '0;
      chunk_size_mib_r <= MIB_W'(1);
      fast_tier_r      <= '0;
      middle_tier_r    <= '0;
      addr_bytes_r     <= 1'b0;
      seen_any_r       <= 1'b0;
      first_stamp_r    <= '0;
      min_index_r      <= '1;
      max_index_r      <= '0;
      distinct_r       <= '0;
      fast_cnt_r       <= '0;
      middle_cnt_r     <= '0;
      slow_cnt_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      clr_addr_r       <= clr_addr_nxt;
      step_r           <= step_nxt;
      chunk_size_mib_r <= chunk_size_mib_nxt;
      fast_tier_r      <= fast_tier_nxt;
      middle_tier_r    <= middle_tier_nxt;
      addr_bytes_r     <= addr_bytes_nxt;
      seen_any_r       <= seen_any_nxt;
      first_stamp_r    <= first_stamp_nxt;
      min_index_r      <= min_index_nxt;
      max_index_r      <= max_index_nxt;
      distinct_r       <= distinct_nxt;
      fast_cnt_r       <= fast_cnt_nxt;
      middle_cnt_r     <= middle_cnt_nxt;
      slow_cnt_r       <= slow_cnt_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    in_range_r <= in_range_nxt;
    tier_r     <= tier_nxt;
    out_data_r <= out_data_nxt;
  end

  // Seen bitmap: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_q_r <= mem[dq_r[SLOT_W-1:0]];
    end
  end

endmodule
